// File: design/segmenting_block_ring_buffer_assert.svh
// Assertion helpers shared by the ring buffer modules.
`ifndef SEGMENTING_BLOCK_RING_BUFFER_ASSERT_SVH
`define SEGMENTING_BLOCK_RING_BUFFER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define SBRB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbrb: assertion failed");

// Next-cycle implication, disabled while reset is held.
`define SBRB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbrb: assertion failed");

`endif

// File: design/sbrb_pkg.sv
package sbrb_pkg;

    localparam int REQ_TYPE_W  = 2;
    localparam int MSG_LEN_W   = 13;
    localparam int BYTE_W      = 8;
    localparam int STATUS_W    = 3;
    localparam int FREE_OUT_W  = 13;
    localparam int QDEPTH      = 2;
    localparam int Q_CNT_W     = 2;

    localparam logic [FREE_OUT_W-1:0] FREE_SAT = 13'h1FFF;

    localparam logic [REQ_TYPE_W-1:0] REQ_OPEN    = 2'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_DATA    = 2'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_READ    = 2'd2;
    localparam logic [REQ_TYPE_W-1:0] REQ_RELEASE = 2'd3;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 3'd0,
        ST_LINK   = 3'd1,
        ST_SPACE  = 3'd2,
        ST_BADLEN = 3'd3,
        ST_EMPTY  = 3'd4,
        ST_UNEXP  = 3'd5
    } t_status;

    // Request class worked out by the front end.
    typedef enum logic [2:0] {
        CLS_OPEN     = 3'd0,
        CLS_LINK_ERR = 3'd1,
        CLS_LEN_ERR  = 3'd2,
        CLS_DATA     = 3'd3,
        CLS_READ     = 3'd4,
        CLS_RELEASE  = 3'd5
    } t_cls;

    typedef struct packed {
        logic [REQ_TYPE_W-1:0] req_type;
        logic                  link_ready;
        logic [MSG_LEN_W-1:0]  msg_len;
        logic [BYTE_W-1:0]     byte_value;
        logic [BYTE_W-1:0]     byte_offset;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [FREE_OUT_W-1:0] free_bytes;
        logic [BYTE_W-1:0]     data_byte;
        logic [BYTE_W-1:0]     block_len;
        logic                  kick_transmit;
    } t_res;

    typedef struct packed {
        t_cls                 cls;
        logic [MSG_LEN_W-1:0] msg_len;
        logic [BYTE_W-1:0]    byte_value;
        logic [BYTE_W-1:0]    byte_offset;
    } t_cmd;

endpackage

// File: design/sbrb_front.sv
`include "segmenting_block_ring_buffer_assert.svh"

module sbrb_front import sbrb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_req i_req,
    output logic o_busy,
    output logic o_cmd_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    t_cmd               cls_cmd;
    t_cmd               r_q [QDEPTH];
    logic               r_wr_ptr;
    logic               r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic               push;

    always_comb begin
        cls_cmd.msg_len     = i_req.msg_len;
        cls_cmd.byte_value  = i_req.byte_value;
        cls_cmd.byte_offset = i_req.byte_offset;
        case (i_req.req_type)
            REQ_OPEN: begin
                if (!i_req.link_ready) begin
                    cls_cmd.cls = CLS_LINK_ERR;
                end else if (i_req.msg_len == '0) begin
                    cls_cmd.cls = CLS_LEN_ERR;
                end else begin
                    cls_cmd.cls = CLS_OPEN;
                end
            end
            REQ_DATA: cls_cmd.cls = CLS_DATA;
            REQ_READ: cls_cmd.cls = CLS_READ;
            default:  cls_cmd.cls = CLS_RELEASE;
        endcase
    end

    assign o_busy      = (r_count == Q_CNT_W'(QDEPTH));
    assign push        = i_start && !o_busy;
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cls_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `SBRB_ASSERT_IMP(a_q_bound, i_clk, i_rst_n, 1'b1, r_count <= Q_CNT_W'(QDEPTH))
    `SBRB_ASSERT_IMP(a_pop_nonempty, i_clk, i_rst_n, i_pop, r_count != '0)
    `SBRB_ASSERT_NXT(a_push_count, i_clk, i_rst_n, push && !i_pop, r_count != '0)

endmodule

// File: design/sbrb_back.sv
`include "segmenting_block_ring_buffer_assert.svh"

module sbrb_back import sbrb_pkg::*; #(
    parameter int NUM_BLOCKS  = 32,
    parameter int BLOCK_BYTES = 240
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cmd_valid,
    input  t_cmd i_cmd,
    output logic o_pop,
    output logic o_done,
    output t_res o_res
);

    localparam int DEPTH  = NUM_BLOCKS * BLOCK_BYTES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SLOT_W = $clog2(NUM_BLOCKS);
    localparam int USED_W = $clog2(NUM_BLOCKS + 1);
    localparam int FILL_W = $clog2(BLOCK_BYTES + 1);
    localparam int FREE_W = $clog2(DEPTH + 1);
    localparam int SUM_W  = ADDR_W + BYTE_W + 1;
    localparam int CMP_W  = ((FREE_W > MSG_LEN_W) ? FREE_W : MSG_LEN_W) + 1;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_BLOCKS - 1);
    localparam logic [ADDR_W-1:0] BB_ADDR   = ADDR_W'(BLOCK_BYTES);
    localparam logic [FREE_W-1:0] BB_FREE   = FREE_W'(BLOCK_BYTES);
    localparam logic [FILL_W-1:0] BB_FILL   = FILL_W'(BLOCK_BYTES);
    localparam logic [FREE_W-1:0] FREE_INIT = FREE_W'(DEPTH);

    typedef enum logic [2:0] {
        BS_IDLE = 3'b001,
        BS_EXEC = 3'b010,
        BS_HEAD = 3'b100
    } t_bstate;

    logic [BYTE_W-1:0]    r_store_mem [DEPTH];
    logic [BYTE_W-1:0]    r_len_mem   [NUM_BLOCKS];

    t_bstate              r_state, n_state;
    t_cmd                 r_cmd;
    logic [BYTE_W-1:0]    r_store_q;
    logic [BYTE_W-1:0]    r_len_q;
    logic [SLOT_W-1:0]    r_wslot, n_wslot;
    logic [SLOT_W-1:0]    r_rslot, n_rslot;
    logic [ADDR_W-1:0]    r_wr_base, n_wr_base;
    logic [ADDR_W-1:0]    r_rd_base, n_rd_base;
    logic [USED_W-1:0]    r_used, n_used;
    logic [FREE_W-1:0]    r_free, n_free;
    logic [MSG_LEN_W-1:0] r_remain, n_remain;
    logic [FILL_W-1:0]    r_fill, n_fill;
    logic [BYTE_W-1:0]    r_head_len, n_head_len;
    logic                 r_done;
    t_res                 r_res;

    logic [USED_W-1:0]    committed;
    logic                 head_ok;
    logic [FILL_W-1:0]    fill_inc;
    logic [ADDR_W-1:0]    wr_addr;
    logic [SUM_W-1:0]     rd_sum;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 in_exec;

    t_status              ex_status;
    logic [BYTE_W-1:0]    ex_data;
    logic                 ex_kick;
    logic                 do_commit;
    logic                 do_release;
    logic                 st_we;
    logic [FILL_W-1:0]    commit_len;
    logic [FREE_OUT_W-1:0] free_out;
    logic [FREE_OUT_W-1:0] free_now;

    // Blocks committed and not yet released; the block being filled is excluded.
    assign committed = r_used - USED_W'(r_fill != '0);
    assign head_ok   = (committed != '0);
    assign fill_inc  = r_fill + 1'b1;
    assign wr_addr   = r_wr_base + ADDR_W'(r_fill);
    assign rd_sum    = SUM_W'(r_rd_base) + SUM_W'(i_cmd.byte_offset);
    assign rd_addr   = rd_sum[ADDR_W-1:0];
    assign in_exec   = (r_state == BS_EXEC);
    assign o_pop     = (r_state == BS_IDLE) && i_cmd_valid;

    always_comb begin
        n_wslot    = r_wslot;
        n_rslot    = r_rslot;
        n_wr_base  = r_wr_base;
        n_rd_base  = r_rd_base;
        n_used     = r_used;
        n_free     = r_free;
        n_remain   = r_remain;
        n_fill     = r_fill;
        n_head_len = r_head_len;
        ex_status  = ST_OK;
        ex_data    = '0;
        ex_kick    = 1'b0;
        do_commit  = 1'b0;
        do_release = 1'b0;
        st_we      = 1'b0;
        commit_len = r_fill;

        case (r_cmd.cls)
            CLS_LINK_ERR: ex_status = ST_LINK;
            CLS_LEN_ERR:  ex_status = ST_BADLEN;
            CLS_OPEN: begin
                if (CMP_W'(r_cmd.msg_len) > CMP_W'(r_free)) begin
                    ex_status = ST_SPACE;
                    ex_kick   = 1'b1;
                end else begin
                    // close out a partly filled block of the previous message
                    if (r_fill != '0) begin
                        do_commit = 1'b1;
                    end
                    n_remain = r_cmd.msg_len;
                    n_fill   = '0;
                end
            end
            CLS_DATA: begin
                if (r_remain == '0) begin
                    ex_status = ST_UNEXP;
                end else begin
                    if (r_fill == '0) begin
                        n_used = r_used + 1'b1;
                        n_free = r_free - BB_FREE;
                    end
                    st_we    = 1'b1;
                    n_remain = r_remain - 1'b1;
                    if (fill_inc == BB_FILL || r_remain == MSG_LEN_W'(1)) begin
                        do_commit  = 1'b1;
                        commit_len = fill_inc;
                    end else begin
                        n_fill = fill_inc;
                    end
                end
            end
            CLS_READ: begin
                if (!head_ok) begin
                    ex_status = ST_EMPTY;
                end else if (r_cmd.byte_offset >= r_head_len) begin
                    ex_status = ST_BADLEN;
                end else begin
                    ex_data = r_store_q;
                end
            end
            CLS_RELEASE: begin
                if (!head_ok) begin
                    ex_status = ST_EMPTY;
                end else begin
                    do_release = 1'b1;
                end
            end
            default: ex_status = ST_OK;
        endcase

        if (do_commit) begin
            ex_kick   = 1'b1;
            n_fill    = '0;
            n_wslot   = (r_wslot == LAST_SLOT) ? '0 : r_wslot + 1'b1;
            n_wr_base = (r_wslot == LAST_SLOT) ? '0 : r_wr_base + BB_ADDR;
            // an empty ring makes the new block the head
            if (!head_ok) begin
                n_head_len = BYTE_W'(commit_len);
            end
        end

        if (do_release) begin
            n_used    = r_used - 1'b1;
            n_free    = r_free + BB_FREE;
            n_rslot   = (r_rslot == LAST_SLOT) ? '0 : r_rslot + 1'b1;
            n_rd_base = (r_rslot == LAST_SLOT) ? '0 : r_rd_base + BB_ADDR;
        end
    end

    assign free_out = (CMP_W'(n_free) > CMP_W'(FREE_SAT)) ? FREE_SAT : FREE_OUT_W'(n_free);
    assign free_now = (CMP_W'(r_free) > CMP_W'(FREE_SAT)) ? FREE_SAT : FREE_OUT_W'(r_free);

    always_comb begin
        case (r_state)
            BS_IDLE: n_state = i_cmd_valid ? BS_EXEC : BS_IDLE;
            BS_EXEC: n_state = do_release ? BS_HEAD : BS_IDLE;
            BS_HEAD: n_state = BS_IDLE;
            default: n_state = BS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_exec && st_we) begin
            r_store_mem[wr_addr] <= r_cmd.byte_value;
        end
        if (o_pop) begin
            r_store_q <= r_store_mem[rd_addr];
        end
    end

    // Lengths are valid only for committed blocks, so the array needs no clearing.
    always_ff @(posedge i_clk) begin
        if (in_exec && do_commit) begin
            r_len_mem[r_wslot] <= BYTE_W'(commit_len);
        end
        r_len_q <= r_len_mem[n_rslot];
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (in_exec && !do_release) begin
            r_res.status        <= ex_status;
            r_res.free_bytes    <= free_out;
            r_res.data_byte     <= ex_data;
            r_res.block_len     <= n_head_len;
            r_res.kick_transmit <= ex_kick;
        end else if (r_state == BS_HEAD) begin
            r_res.status        <= ST_OK;
            r_res.free_bytes    <= free_now;
            r_res.data_byte     <= '0;
            r_res.block_len     <= head_ok ? r_len_q : '0;
            r_res.kick_transmit <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= BS_IDLE;
            r_wslot    <= '0;
            r_rslot    <= '0;
            r_wr_base  <= '0;
            r_rd_base  <= '0;
            r_used     <= '0;
            r_free     <= FREE_INIT;
            r_remain   <= '0;
            r_fill     <= '0;
            r_head_len <= '0;
            r_done     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (in_exec && !do_release) || (r_state == BS_HEAD);
            if (in_exec) begin
                r_wslot    <= n_wslot;
                r_rslot    <= n_rslot;
                r_wr_base  <= n_wr_base;
                r_rd_base  <= n_rd_base;
                r_used     <= n_used;
                r_free     <= n_free;
                r_remain   <= n_remain;
                r_fill     <= n_fill;
                r_head_len <= n_head_len;
            end else if (r_state == BS_HEAD) begin
                // pick up the length of the new head block
                r_head_len <= head_ok ? r_len_q : '0;
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

    `SBRB_ASSERT_NXT(a_done_single, i_clk, i_rst_n, r_done, !r_done)
    `SBRB_ASSERT_IMP(a_used_bound, i_clk, i_rst_n, 1'b1, r_used <= USED_W'(NUM_BLOCKS))
    `SBRB_ASSERT_IMP(a_fill_counted, i_clk, i_rst_n, r_fill != '0, r_used != '0)

endmodule

// File: design/segmenting_block_ring_buffer.sv
// Channel   Handshake                      Beat
// command   start in, busy out             i_req  (t_req)
// result    o_done strobe, no back-press   o_res  (t_res)
//
// A command is taken at an edge with start high and busy low, and lands in a
// two-entry queue; busy is high only while that queue is full.
// The executing side takes each command through the idle state, which pops it with
// a registered block-store read, and then the execute state; a release goes on to a
// head state that fetches the new head block's length from the length array.
// From an idle block, an accepted command passes the queue register, the idle-state pop
// and the execute state (for a release also the head state); o_done and the beat are registered together.
// Reset is synchronous and empties the queue and the ring; block contents
// stay undefined until written.
module segmenting_block_ring_buffer import sbrb_pkg::*; #(
    parameter int NUM_BLOCKS  = 32,
    parameter int BLOCK_BYTES = 240
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_done,
    output t_res o_res
);

    logic cmd_valid;
    t_cmd cmd;
    logic pop;

    sbrb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_req       (i_req),
        .o_busy      (busy),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_pop       (pop)
    );

    sbrb_back #(
        .NUM_BLOCKS  (NUM_BLOCKS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_pop       (pop),
        .o_done      (o_done),
        .o_res       (o_res)
    );

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import sbrb_pkg::*;

    localparam int NUM_BLOCKS   = 32;
    localparam int BLOCK_BYTES  = 240;
    localparam int RING_BYTES   = NUM_BLOCKS * BLOCK_BYTES;
    localparam int RANDOM_BEATS = 1930;
    localparam int TAIL_CYCLES  = 16;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PRINT_CAP    = 50;

    typedef struct {
        t_req req;
        bit   typed;
        t_res res;
    } t_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_req i_req   = '0;
    logic busy;
    logic o_done;
    t_res o_res;

    // shadow copy of the ring
    logic [7:0]  ring_bytes [RING_BYTES];
    logic [7:0]  ring_len [NUM_BLOCKS];
    int unsigned wr_slot;
    int unsigned rd_slot;
    int unsigned blocks_in_use;
    int unsigned owed_bytes;
    int unsigned fill_pos;

    t_res pending_res [$];
    t_row dir_rows [$];
    int   mismatch_count = 0;
    int   cycle_count    = 0;
    int   idle_pct       = 0;

    segmenting_block_ring_buffer #(
        .NUM_BLOCKS  (NUM_BLOCKS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_done  (o_done),
        .o_res   (o_res)
    );

    always #2 i_clk = ~i_clk;

    function automatic int unsigned next_slot(input int unsigned s);
        return (s + 1 >= NUM_BLOCKS) ? 0 : s + 1;
    endfunction

    function automatic int unsigned ring_free_bytes();
        int unsigned empty_blocks;
        empty_blocks = (blocks_in_use < NUM_BLOCKS) ? NUM_BLOCKS - blocks_in_use : 0;
        return empty_blocks * BLOCK_BYTES;
    endfunction

    // Close the block being filled with what it holds and advance.
    function automatic void seal_block();
        ring_len[wr_slot] = fill_pos[7:0];
        wr_slot = next_slot(wr_slot);
        fill_pos = 0;
    endfunction

    function automatic t_res predict_response(input t_req r);
        t_res        res;
        int unsigned head_len;
        int unsigned free_b;
        res = '0;
        res.status = ST_OK;
        case (r.req_type)
            REQ_OPEN: begin
                if (!r.link_ready) begin
                    res.status = ST_LINK;
                end else if (r.msg_len == 0) begin
                    res.status = ST_BADLEN;
                end else if (32'(r.msg_len) > ring_free_bytes()) begin
                    res.status = ST_SPACE;
                    res.kick_transmit = 1'b1;
                end else begin
                    if (fill_pos > 0) begin
                        seal_block();
                        res.kick_transmit = 1'b1;
                    end
                    owed_bytes = 32'(r.msg_len);
                    fill_pos = 0;
                end
            end
            REQ_DATA: begin
                if (owed_bytes == 0) begin
                    res.status = ST_UNEXP;
                end else begin
                    if (fill_pos == 0) blocks_in_use++;
                    ring_bytes[wr_slot * BLOCK_BYTES + fill_pos] = r.byte_value;
                    fill_pos++;
                    owed_bytes--;
                    if (fill_pos >= BLOCK_BYTES || owed_bytes == 0) begin
                        seal_block();
                        res.kick_transmit = 1'b1;
                    end
                end
            end
            REQ_READ: begin
                head_len = 32'(ring_len[rd_slot]);
                if (head_len == 0) res.status = ST_EMPTY;
                else if (32'(r.byte_offset) >= head_len) res.status = ST_BADLEN;
                else res.data_byte = ring_bytes[rd_slot * BLOCK_BYTES + r.byte_offset];
            end
            default: begin
                if (ring_len[rd_slot] == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    ring_len[rd_slot] = '0;
                    rd_slot = next_slot(rd_slot);
                    if (blocks_in_use > 0) blocks_in_use--;
                end
            end
        endcase
        free_b = ring_free_bytes();
        res.free_bytes = (free_b > FREE_SAT) ? FREE_SAT : free_b[FREE_OUT_W-1:0];
        res.block_len = ring_len[rd_slot];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("%0t: %s got %0d want %0d", $time, what, got, want);
    endtask

    // Drive one beat; the expected result is recorded at the accepting edge.
    task automatic issue_req(input t_req r, input bit typed, input t_res typed_res,
                             output t_res exp);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        exp = predict_response(r);
        if (typed) exp = typed_res;
        pending_res.push_back(exp);
        @(negedge i_clk);
    endtask

    task automatic add_row(input logic [REQ_TYPE_W-1:0] kind, input logic link,
                           input int len, input int val, input int off,
                           input bit typed, input t_status st);
        t_row row;
        row.req = '0;
        row.req.req_type = kind;
        row.req.link_ready = link;
        row.req.msg_len = MSG_LEN_W'(len);
        row.req.byte_value = BYTE_W'(val);
        row.req.byte_offset = BYTE_W'(off);
        row.typed = typed;
        row.res = '0;
        row.res.status = st;
        row.res.free_bytes = FREE_OUT_W'(RING_BYTES);
        dir_rows.push_back(row);
    endtask

    always @(posedge i_clk) begin
        t_res exp;
        if (i_rst_n && o_done) begin
            if (pending_res.size() == 0) begin
                report_mismatch("result beat with nothing pending, status", o_res.status, -1);
            end else begin
                exp = pending_res.pop_front();
                if (o_res.status !== exp.status)
                    report_mismatch("status", o_res.status, exp.status);
                if (o_res.free_bytes !== exp.free_bytes)
                    report_mismatch("free_bytes", o_res.free_bytes, exp.free_bytes);
                if (o_res.data_byte !== exp.data_byte)
                    report_mismatch("data_byte", o_res.data_byte, exp.data_byte);
                if (o_res.block_len !== exp.block_len)
                    report_mismatch("block_len", o_res.block_len, exp.block_len);
                if (o_res.kick_transmit !== exp.kick_transmit)
                    report_mismatch("kick_transmit", o_res.kick_transmit, exp.kick_transmit);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        t_req        r;
        t_res        exp;
        int unsigned planned_bytes;
        int unsigned drain_pct;
        int unsigned head_len;
        int unsigned free_b;
        int unsigned sel;
        int          idle_steps [3];
        int          drain_steps [3];

        idle_steps = '{0, 75, 12};
        drain_steps = '{10, 35, 60};
        planned_bytes = 0;

        foreach (ring_bytes[i]) ring_bytes[i] = '0;
        foreach (ring_len[i]) ring_len[i] = '0;
        wr_slot = 0;
        rd_slot = 0;
        blocks_in_use = 0;
        owed_bytes = 0;
        fill_pos = 0;

        // empty ring and rejected opens
        add_row(REQ_READ,    1'b1, 0,    0,    0,   1, ST_EMPTY);
        add_row(REQ_RELEASE, 1'b1, 0,    0,    0,   1, ST_EMPTY);
        add_row(REQ_DATA,    1'b1, 0,    8'hFF, 0,  1, ST_UNEXP);
        add_row(REQ_OPEN,    1'b0, 7680, 0,    0,   1, ST_LINK);
        add_row(REQ_OPEN,    1'b1, 0,    0,    0,   1, ST_BADLEN);
        // full-ring open abandoned before any byte
        add_row(REQ_OPEN,    1'b1, 7680, 0,    0,   0, ST_OK);
        add_row(REQ_OPEN,    1'b1, 3,    0,    0,   0, ST_OK);
        add_row(REQ_DATA,    1'b1, 0,    8'h00, 0,  0, ST_OK);
        add_row(REQ_DATA,    1'b1, 0,    8'hFF, 0,  0, ST_OK);
        add_row(REQ_DATA,    1'b1, 0,    8'h5A, 0,  0, ST_OK);
        add_row(REQ_DATA,    1'b0, 8191, 8'h11, 255, 0, ST_OK);
        add_row(REQ_OPEN,    1'b1, 7680, 0,    0,   0, ST_OK);
        add_row(REQ_READ,    1'b1, 0,    0,    0,   0, ST_OK);
        add_row(REQ_READ,    1'b1, 0,    0,    2,   0, ST_OK);
        add_row(REQ_READ,    1'b1, 0,    0,    3,   0, ST_OK);
        add_row(REQ_READ,    1'b1, 0,    0,    239, 0, ST_OK);
        // open during a message seals the partial block
        add_row(REQ_OPEN,    1'b1, 5,    0,    0,   0, ST_OK);
        add_row(REQ_DATA,    1'b1, 0,    8'h80, 0,  0, ST_OK);
        add_row(REQ_OPEN,    1'b1, 1,    0,    0,   0, ST_OK);
        add_row(REQ_DATA,    1'b1, 0,    8'h01, 0,  0, ST_OK);
        add_row(REQ_RELEASE, 1'b1, 0,    0,    0,   0, ST_OK);
        add_row(REQ_READ,    1'b1, 0,    0,    0,   0, ST_OK);
        add_row(REQ_RELEASE, 1'b1, 0,    0,    0,   0, ST_OK);
        add_row(REQ_RELEASE, 1'b1, 0,    0,    0,   0, ST_OK);
        add_row(REQ_RELEASE, 1'b1, 0,    0,    0,   0, ST_OK);

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            issue_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res, exp);

        for (int n = 0; n < RANDOM_BEATS; n++) begin
            idle_pct = idle_steps[(n / 150) % 3];
            drain_pct = drain_steps[(n / 200) % 3];
            r = '0;
            r.link_ready = 1'($urandom_range(1));
            r.msg_len = MSG_LEN_W'($urandom_range(7680));
            r.byte_value = BYTE_W'($urandom_range(255));
            r.byte_offset = BYTE_W'($urandom_range(239));
            head_len = 32'(ring_len[rd_slot]);

            if ($urandom_range(99) < drain_pct) begin
                if ($urandom_range(99) < 60) begin
                    r.req_type = REQ_READ;
                    if (head_len > 0 && $urandom_range(99) < 80)
                        r.byte_offset = BYTE_W'($urandom_range(head_len - 1));
                end else begin
                    r.req_type = REQ_RELEASE;
                end
            end else if (planned_bytes > 0) begin
                r.req_type = REQ_DATA;
                planned_bytes--;
            end else if ($urandom_range(19) == 0) begin
                r.req_type = REQ_DATA;
            end else begin
                // mostly short messages so the ring fills and wraps
                r.req_type = REQ_OPEN;
                r.link_ready = ($urandom_range(15) != 0);
                free_b = ring_free_bytes();
                sel = $urandom_range(99);
                if (sel < 65) r.msg_len = MSG_LEN_W'($urandom_range(6, 1));
                else if (sel < 80) r.msg_len = MSG_LEN_W'($urandom_range(250, 7));
                else if (sel < 85) r.msg_len = MSG_LEN_W'($urandom_range(480, 241));
                else if (sel < 93)
                    r.msg_len = MSG_LEN_W'((free_b > 0) ? $urandom_range(free_b, 1) : 1);
                else if (sel < 96) r.msg_len = '0;
            end

            issue_req(r, 1'b0, '0, exp);

            if (r.req_type == REQ_OPEN && exp.status == ST_OK) begin
                // cut long messages short with a later open
                if (r.msg_len <= 480 && $urandom_range(99) < 85)
                    planned_bytes = 32'(r.msg_len);
                else
                    planned_bytes = $urandom_range((r.msg_len < 40) ? 32'(r.msg_len) : 40, 1);
            end
        end

        start <= 1'b0;
        while (pending_res.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+design
design/sbrb_pkg.sv
design/sbrb_front.sv
design/sbrb_back.sv
design/segmenting_block_ring_buffer.sv
tb/tb_top.sv
